>>> hw/rtl/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types and constants of the streaming Pearson correlation block.
// ----------------------------------------------------------------------------
package pcs_pkg;

    localparam int SUM_W = 32;
    localparam int SQ_W  = 56;
    localparam int CNT_W = 9;
    localparam int COR_W = 16;
    localparam int Q_W   = 15;
    localparam int ACC_W = 160;

    localparam logic [Q_W-1:0] Q_ONE = 15'd16384;
    localparam logic [3:0]     Q_TOP_BIT = 4'd14;

    // finished series sums handed from the front end to the back end
    typedef struct packed {
        logic [SUM_W-1:0] sum_price;
        logic [SUM_W-1:0] sum_volume;
        logic [SQ_W-1:0]  sum_price_sq;
        logic [SQ_W-1:0]  sum_volume_sq;
        logic [SQ_W-1:0]  sum_cross;
        logic [CNT_W-1:0] pairs;
        logic             overflowed;
    } pcs_series_t;

    // multi-limb product jobs run on the shared multiplier
    typedef enum logic [3:0] {
        OP_NSXY,
        OP_SXSY,
        OP_NSXX,
        OP_SXSX,
        OP_NSYY,
        OP_SYSY,
        OP_NN,
        OP_PV,
        OP_SQ,
        OP_LHS
    } pcs_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_WB,
        ST_SUB,
        ST_CHECK,
        ST_TRY,
        ST_CMP,
        ST_OUT
    } pcs_state_t;

endpackage

>>> hw/rtl/pcs_front.sv
// ----------------------------------------------------------------------------
// pcs_front
// Accepts paired samples, forms the squares and cross product in a register
// stage, then accumulates them; on the last sample pushes the series sums.
// ----------------------------------------------------------------------------
module pcs_front #(
    parameter int MAX_SERIES_LEN = 256,
    parameter int SAMPLE_BITS    = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [23:0]         s_price,
    input  logic                s_price_valid,
    input  logic [23:0]         s_volume,
    input  logic                s_volume_valid,
    input  logic                s_last,
    output logic                out_valid,
    input  logic                out_ready,
    output pcs_pkg::pcs_series_t out_series
);
    import pcs_pkg::*;

    localparam int PROD_W = 2 * SAMPLE_BITS;

    logic                   st_valid_reg;
    logic [SAMPLE_BITS-1:0] x_reg, y_reg;
    logic [PROD_W-1:0]      xx_reg, yy_reg, xy_reg;
    logic                   both_reg, last_reg;

    logic [SUM_W-1:0] sum_price_reg, sum_volume_reg, sum_price_next, sum_volume_next;
    logic [SQ_W-1:0]  sum_price_sq_reg, sum_volume_sq_reg, sum_cross_reg;
    logic [SQ_W-1:0]  sum_price_sq_next, sum_volume_sq_next, sum_cross_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;

    logic [SAMPLE_BITS-1:0] x_in, y_in;
    logic commit, accept, full, take;

    assign x_in   = s_price[SAMPLE_BITS-1:0];
    assign y_in   = s_volume[SAMPLE_BITS-1:0];
    assign commit = st_valid_reg && (!last_reg || out_ready);
    assign s_ready = !st_valid_reg || commit;
    assign accept = s_valid && s_ready;

    assign full = cnt_reg >= CNT_W'(MAX_SERIES_LEN);
    assign take = both_reg && !full;

    always_comb begin
        sum_price_next     = sum_price_reg + (take ? SUM_W'(x_reg) : '0);
        sum_volume_next    = sum_volume_reg + (take ? SUM_W'(y_reg) : '0);
        sum_price_sq_next  = sum_price_sq_reg + (take ? SQ_W'(xx_reg) : '0);
        sum_volume_sq_next = sum_volume_sq_reg + (take ? SQ_W'(yy_reg) : '0);
        sum_cross_next     = sum_cross_reg + (take ? SQ_W'(xy_reg) : '0);
        cnt_next           = cnt_reg + CNT_W'(take);
        ovf_next           = ovf_reg | (both_reg & full);
    end

    assign out_valid                = st_valid_reg && last_reg;
    assign out_series.sum_price     = sum_price_next;
    assign out_series.sum_volume    = sum_volume_next;
    assign out_series.sum_price_sq  = sum_price_sq_next;
    assign out_series.sum_volume_sq = sum_volume_sq_next;
    assign out_series.sum_cross     = sum_cross_next;
    assign out_series.pairs         = cnt_next;
    assign out_series.overflowed    = ovf_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (s_ready) begin
            st_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg    <= x_in;
            y_reg    <= y_in;
            xx_reg   <= PROD_W'(x_in) * PROD_W'(x_in);
            yy_reg   <= PROD_W'(y_in) * PROD_W'(y_in);
            xy_reg   <= PROD_W'(x_in) * PROD_W'(y_in);
            both_reg <= s_price_valid & s_volume_valid;
            last_reg <= s_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (commit && last_reg)) begin
            sum_price_reg     <= '0;
            sum_volume_reg    <= '0;
            sum_price_sq_reg  <= '0;
            sum_volume_sq_reg <= '0;
            sum_cross_reg     <= '0;
            cnt_reg           <= '0;
            ovf_reg           <= 1'b0;
        end else if (commit) begin
            sum_price_reg     <= sum_price_next;
            sum_volume_reg    <= sum_volume_next;
            sum_price_sq_reg  <= sum_price_sq_next;
            sum_volume_sq_reg <= sum_volume_sq_next;
            sum_cross_reg     <= sum_cross_next;
            cnt_reg           <= cnt_next;
            ovf_reg           <= ovf_next;
        end
    end

endmodule

>>> hw/rtl/pcs_queue.sv
// ----------------------------------------------------------------------------
// pcs_queue
// Two-entry queue of finished series between the front and back ends.
// ----------------------------------------------------------------------------
module pcs_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pcs_pkg::pcs_series_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pcs_pkg::pcs_series_t out_data
);
    import pcs_pkg::*;

    pcs_series_t entry_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push, pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

>>> hw/rtl/pcs_back.sv
// ----------------------------------------------------------------------------
// pcs_back
// Finishes one series: products on one shared 32x32 multiplier limb by limb,
// the variance terms, then a bitwise search for the rounded coefficient.
// ----------------------------------------------------------------------------
module pcs_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pcs_pkg::pcs_series_t in_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [15:0]   m_correlation,
    output logic                 m_corr_valid,
    output logic [8:0]           m_pair_count,
    output logic                 m_overflow
);
    import pcs_pkg::*;

    pcs_state_t state_reg, state_next;
    pcs_op_t    op_reg, op_next;
    logic [1:0] ai_reg;
    logic       bi_reg;
    logic       m_valid_reg;

    logic [SUM_W-1:0] sx_reg, sy_reg;
    logic [SQ_W-1:0]  sxx_reg, syy_reg, sxy_reg;
    logic [CNT_W-1:0] n_reg;
    logic             ovf_reg;
    logic [63:0]      nsxy_reg, sxsy_reg, nsxx_reg, sxsx_reg, nsyy_reg, sysy_reg;
    logic [63:0]      num_reg, vx_reg, vy_reg;
    logic             neg_reg, ok_reg;
    logic [127:0]     nn_reg, p_reg;
    logic [63:0]      prod_reg;
    logic [1:0]       sh_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [Q_W-1:0]   q_reg, cand_reg;
    logic [3:0]       k_reg;
    logic [29:0]      sq_reg;
    logic signed [COR_W-1:0] cor_reg;
    logic             cv_reg, ovo_reg;
    logic [CNT_W-1:0] pc_reg;

    logic [127:0]     a_opnd;
    logic [63:0]      b_opnd;
    logic [1:0]       na_m1;
    logic             nb_m1;
    logic [31:0]      a_limb, b_limb;
    logic             last_part, ok_calc, out_free, lhs_le;
    logic [Q_W-1:0]   cand_calc;
    logic [Q_W:0]     odd;
    logic [ACC_W-1:0] addend, rhs;

    assign in_ready = state_reg == ST_IDLE;
    assign out_free = !m_valid_reg || m_ready;
    assign odd      = {cand_reg, 1'b0} - 16'd1;
    assign cand_calc = q_reg | (Q_W'(1) << k_reg);
    assign ok_calc  = (n_reg >= CNT_W'(2)) && !ovf_reg && (vx_reg != '0) && (vy_reg != '0);
    assign rhs      = ACC_W'({nn_reg, 30'b0});
    assign lhs_le   = acc_reg <= rhs;
    assign addend   = ACC_W'(prod_reg) << {sh_reg, 5'b0};

    // operand selection for the current product job
    always_comb begin
        a_opnd = '0;
        b_opnd = '0;
        na_m1  = 2'd0;
        nb_m1  = 1'b0;
        unique case (op_reg)
            OP_NSXY: begin a_opnd = 128'(sxy_reg); b_opnd = 64'(n_reg); na_m1 = 2'd1; end
            OP_SXSY: begin a_opnd = 128'(sx_reg);  b_opnd = 64'(sy_reg); end
            OP_NSXX: begin a_opnd = 128'(sxx_reg); b_opnd = 64'(n_reg); na_m1 = 2'd1; end
            OP_SXSX: begin a_opnd = 128'(sx_reg);  b_opnd = 64'(sx_reg); end
            OP_NSYY: begin a_opnd = 128'(syy_reg); b_opnd = 64'(n_reg); na_m1 = 2'd1; end
            OP_SYSY: begin a_opnd = 128'(sy_reg);  b_opnd = 64'(sy_reg); end
            OP_NN: begin
                a_opnd = 128'(num_reg); b_opnd = num_reg; na_m1 = 2'd1; nb_m1 = 1'b1;
            end
            OP_PV: begin
                a_opnd = 128'(vx_reg); b_opnd = vy_reg; na_m1 = 2'd1; nb_m1 = 1'b1;
            end
            OP_SQ:  begin a_opnd = 128'(odd); b_opnd = 64'(odd); end
            OP_LHS: begin a_opnd = p_reg; b_opnd = 64'(sq_reg); na_m1 = 2'd3; end
            default: begin end
        endcase
    end

    assign a_limb    = a_opnd[32*ai_reg +: 32];
    assign b_limb    = b_opnd[32*bi_reg +: 32];
    assign last_part = (ai_reg == na_m1) && (bi_reg == nb_m1);

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_MUL;
                    op_next    = OP_NSXY;
                end
            end
            ST_MUL: state_next = ST_ADD;
            ST_ADD: state_next = last_part ? ST_WB : ST_MUL;
            ST_WB: begin
                state_next = ST_MUL;
                unique case (op_reg)
                    OP_NSXY: op_next = OP_SXSY;
                    OP_SXSY: op_next = OP_NSXX;
                    OP_NSXX: op_next = OP_SXSX;
                    OP_SXSX: op_next = OP_NSYY;
                    OP_NSYY: op_next = OP_SYSY;
                    OP_SYSY: state_next = ST_SUB;
                    OP_NN:   op_next = OP_PV;
                    OP_PV:   state_next = ST_TRY;
                    OP_SQ:   op_next = OP_LHS;
                    OP_LHS:  state_next = ST_CMP;
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_SUB: state_next = ST_CHECK;
            ST_CHECK: begin
                if (ok_calc) begin
                    state_next = ST_MUL;
                    op_next    = OP_NN;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_TRY: begin
                if (cand_calc > Q_ONE) begin
                    state_next = (k_reg == 4'd0) ? ST_OUT : ST_TRY;
                end else begin
                    state_next = ST_MUL;
                    op_next    = OP_SQ;
                end
            end
            ST_CMP: state_next = (k_reg == 4'd0) ? ST_OUT : ST_TRY;
            ST_OUT: state_next = out_free ? ST_IDLE : ST_OUT;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_NSXY;
            ai_reg      <= 2'd0;
            bi_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            if (state_reg == ST_ADD) begin
                if (last_part) begin
                    ai_reg <= 2'd0;
                    bi_reg <= 1'b0;
                end else if (ai_reg == na_m1) begin
                    ai_reg <= 2'd0;
                    bi_reg <= 1'b1;
                end else begin
                    ai_reg <= ai_reg + 2'd1;
                end
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                sx_reg  <= in_data.sum_price;
                sy_reg  <= in_data.sum_volume;
                sxx_reg <= in_data.sum_price_sq;
                syy_reg <= in_data.sum_volume_sq;
                sxy_reg <= in_data.sum_cross;
                n_reg   <= in_data.pairs;
                ovf_reg <= in_data.overflowed;
            end
            ST_MUL: begin
                prod_reg <= 64'(a_limb) * 64'(b_limb);
                sh_reg   <= ai_reg + 2'(bi_reg);
                // first partial of a job starts a fresh sum
                if (ai_reg == 2'd0 && !bi_reg) acc_reg <= '0;
            end
            ST_ADD: acc_reg <= acc_reg + addend;
            ST_WB: begin
                unique case (op_reg)
                    OP_NSXY: nsxy_reg <= acc_reg[63:0];
                    OP_SXSY: sxsy_reg <= acc_reg[63:0];
                    OP_NSXX: nsxx_reg <= acc_reg[63:0];
                    OP_SXSX: sxsx_reg <= acc_reg[63:0];
                    OP_NSYY: nsyy_reg <= acc_reg[63:0];
                    OP_SYSY: sysy_reg <= acc_reg[63:0];
                    OP_NN:   nn_reg   <= acc_reg[127:0];
                    OP_PV: begin
                        p_reg <= acc_reg[127:0];
                        q_reg <= '0;
                        k_reg <= Q_TOP_BIT;
                    end
                    OP_SQ:   sq_reg <= acc_reg[29:0];
                    OP_LHS:  begin end
                    default: begin end
                endcase
            end
            ST_SUB: begin
                if (nsxy_reg >= sxsy_reg) begin
                    num_reg <= nsxy_reg - sxsy_reg;
                    neg_reg <= 1'b0;
                end else begin
                    num_reg <= sxsy_reg - nsxy_reg;
                    neg_reg <= 1'b1;
                end
                vx_reg <= (nsxx_reg > sxsx_reg) ? nsxx_reg - sxsx_reg : '0;
                vy_reg <= (nsyy_reg > sysy_reg) ? nsyy_reg - sysy_reg : '0;
            end
            ST_CHECK: begin
                ok_reg <= ok_calc;
                q_reg  <= '0;
            end
            ST_TRY: begin
                cand_reg <= cand_calc;
                if (cand_calc > Q_ONE && k_reg != 4'd0) k_reg <= k_reg - 4'd1;
            end
            ST_CMP: begin
                if (lhs_le) q_reg <= cand_reg;
                if (k_reg != 4'd0) k_reg <= k_reg - 4'd1;
            end
            ST_OUT: begin
                if (out_free) begin
                    cor_reg <= neg_reg ? COR_W'(16'd0 - 16'(q_reg)) : COR_W'(q_reg);
                    cv_reg  <= ok_reg;
                    pc_reg  <= n_reg;
                    ovo_reg <= ovf_reg;
                end
            end
            default: begin end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_correlation = cor_reg;
    assign m_corr_valid  = cv_reg;
    assign m_pair_count  = pc_reg;
    assign m_overflow    = ovo_reg;

endmodule

>>> hw/rtl/pearson_correlation_stream.sv
// ----------------------------------------------------------------------------
// pearson_correlation_stream
// Streaming Pearson correlation of paired price and volume samples, Q2.14 out.
// ----------------------------------------------------------------------------
// throughput: one sample per cycle while the two-entry series queue has room
// path: a series reaches the back end through the sample register stage and the
//   queue after its last sample; its result then follows a bitwise search over
//   15 bits, skipped when no coefficient is formed, bounded by the shared
//   32x32 multiplier working limb by limb
// reset: synchronous active-low aresetn clears all sums, the queue and the
//   output valid flag; no clearing pass is needed
module pearson_correlation_stream #(
    parameter int MAX_SERIES_LEN = 256,
    parameter int SAMPLE_BITS    = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [23:0]        s_price,
    input  logic               s_price_valid,
    input  logic [23:0]        s_volume,
    input  logic               s_volume_valid,
    input  logic               s_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_correlation,
    output logic               m_corr_valid,
    output logic [8:0]         m_pair_count,
    output logic               m_overflow
);
    import pcs_pkg::*;

    logic        f_valid, f_ready, q_valid, q_ready;
    pcs_series_t f_series, q_series;

    pcs_front #(
        .MAX_SERIES_LEN(MAX_SERIES_LEN),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_price       (s_price),
        .s_price_valid (s_price_valid),
        .s_volume      (s_volume),
        .s_volume_valid(s_volume_valid),
        .s_last        (s_last),
        .out_valid     (f_valid),
        .out_ready     (f_ready),
        .out_series    (f_series)
    );

    pcs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (f_valid),
        .in_ready (f_ready),
        .in_data  (f_series),
        .out_valid(q_valid),
        .out_ready(q_ready),
        .out_data (q_series)
    );

    pcs_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (q_valid),
        .in_ready     (q_ready),
        .in_data      (q_series),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_correlation(m_correlation),
        .m_corr_valid (m_corr_valid),
        .m_pair_count (m_pair_count),
        .m_overflow   (m_overflow)
    );

    a_valid_not_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_corr_valid && m_overflow))
        else $error("valid correlation reported with overflow");

    a_valid_needs_pairs: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_corr_valid) |-> (m_pair_count >= 9'd2))
        else $error("valid correlation from fewer than two pairs");

    a_corr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_correlation <= 16'sd16384 && m_correlation >= -16'sd16384))
        else $error("correlation out of range");

    a_ovf_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_overflow) |-> (m_pair_count == 9'(MAX_SERIES_LEN)))
        else $error("overflowed series does not show the full count");

endmodule
